/* rtl/segi_pkg.sv */
// Package for the segment intersection block: widths, the job record passed
// from the front part to the back part, and queue sizing.
// No dependencies.
package segi_pkg;

  localparam int unsigned CoordW = 32;            // coordinate field width
  localparam int unsigned DiffW  = CoordW + 1;    // coordinate difference
  localparam int unsigned ProdW  = 2 * DiffW;     // signed product of differences
  localparam int unsigned MagW   = ProdW - 1;     // magnitude of den and tnum
  localparam int unsigned LoW    = CoordW;        // low slice of tnum for the split multiply
  localparam int unsigned HiW    = MagW - LoW;    // high slice of tnum
  localparam int unsigned NumW   = MagW + CoordW; // tnum * |db| magnitude
  localparam int unsigned QuoW   = CoordW;        // quotient bits, one per divider stage
  localparam int unsigned SumW   = CoordW + 2;    // signed sum before truncation

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);

  typedef struct packed {
    logic                     hit;
    logic [MagW-1:0]          tnum;
    logic [MagW-1:0]          den;
    logic signed [DiffW-1:0]  dbx;
    logic signed [DiffW-1:0]  dby;
    logic signed [CoordW-1:0] q0x;
    logic signed [CoordW-1:0] q0y;
  } seg_job_t;

endpackage

/* rtl/segment_intersection.sv */
// Top level of the segment intersection block.
// Depends on segi_pkg, segi_front, segi_queue and segi_back.
//
// Usage. A segment pair is transferred in at a rising edge where start is
// high and busy is low; the eight coordinates are signed Q16.16 and
// in_ignore_a_range turns segment A into an unbounded line. Each pair gives
// exactly one result: out_valid is high for one cycle with out_hit and the
// crossing point on out_cross_x and out_cross_y, both zero when there is
// no hit. The point is exact, rounded towards minus infinity.
//
// A new pair may be transferred in every cycle while busy is low. The front
// part registers the differences, the products, the cross products and the
// range check in turn, the queue registers its count, and the back part has
// a multiply stage, a sum stage, the 32-stage divider with one quotient bit
// per stage and an output stage. The divider stages set the latency; every
// unit is fully pipelined, so throughput is one pair per clock.
//
// Reset (rst_n low, synchronous) empties the pipeline and the queue; no
// result appears for pairs in flight. The receiver cannot stall, and busy
// only rises if the queue between the parts were ever to fill.
module segment_intersection (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [segi_pkg::CoordW-1:0] in_a_start_x,
  input  logic signed [segi_pkg::CoordW-1:0] in_a_start_y,
  input  logic signed [segi_pkg::CoordW-1:0] in_a_end_x,
  input  logic signed [segi_pkg::CoordW-1:0] in_a_end_y,
  input  logic signed [segi_pkg::CoordW-1:0] in_b_start_x,
  input  logic signed [segi_pkg::CoordW-1:0] in_b_start_y,
  input  logic signed [segi_pkg::CoordW-1:0] in_b_end_x,
  input  logic signed [segi_pkg::CoordW-1:0] in_b_end_y,
  input  logic                             in_ignore_a_range,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic signed [segi_pkg::CoordW-1:0] out_cross_x,
  output logic signed [segi_pkg::CoordW-1:0] out_cross_y
);
  import segi_pkg::*;

  logic     take, push, q_valid, q_full;
  seg_job_t f_job, q_job;

  // A transfer in happens whenever start meets a non-full queue.
  assign take = start && !busy;
  assign busy = q_full;

  segi_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .p0x   (in_a_start_x),
    .p0y   (in_a_start_y),
    .p1x   (in_a_end_x),
    .p1y   (in_a_end_y),
    .q0x   (in_b_start_x),
    .q0y   (in_b_start_y),
    .q1x   (in_b_end_x),
    .q1y   (in_b_end_y),
    .ign   (in_ignore_a_range),
    .push  (push),
    .job   (f_job)
  );

  segi_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_job   (f_job),
    .rd_valid (q_valid),
    .rd_job   (q_job),
    .full     (q_full)
  );

  segi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (q_valid),
    .job     (q_job),
    .res_vld (out_valid),
    .res_hit (out_hit),
    .res_x   (out_cross_x),
    .res_y   (out_cross_y)
  );

  // A miss must report the origin.
  a_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_cross_x == '0 && out_cross_y == '0))
    else $error("crossing point not zero on a miss");

  // The back part drains one job per cycle, so the queue never fills.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("queue between front and back filled up");

  // Every transfer in yields its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##40 out_valid)
    else $error("result missing after pipeline latency");

endmodule

/* rtl/segi_front.sv */
// Front part: differences, cross products and the range classification.
// Depends on segi_pkg.
module segi_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             take,
  input  logic signed [segi_pkg::CoordW-1:0] p0x,
  input  logic signed [segi_pkg::CoordW-1:0] p0y,
  input  logic signed [segi_pkg::CoordW-1:0] p1x,
  input  logic signed [segi_pkg::CoordW-1:0] p1y,
  input  logic signed [segi_pkg::CoordW-1:0] q0x,
  input  logic signed [segi_pkg::CoordW-1:0] q0y,
  input  logic signed [segi_pkg::CoordW-1:0] q1x,
  input  logic signed [segi_pkg::CoordW-1:0] q1y,
  input  logic                             ign,
  output logic                             push,
  output segi_pkg::seg_job_t               job
);
  import segi_pkg::*;

  // stage 1: differences
  logic                     v1_r;
  logic signed [DiffW-1:0]  dax_r, day_r, dbx_r, dby_r, wx_r, wy_r;
  logic signed [CoordW-1:0] q0x1_r, q0y1_r;
  logic                     ign1_r;
  // stage 2: products
  logic                     v2_r;
  logic signed [ProdW-1:0]  m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [DiffW-1:0]  dbx2_r, dby2_r;
  logic signed [CoordW-1:0] q0x2_r, q0y2_r;
  logic                     ign2_r;
  // stage 3: cross products
  logic                     v3_r;
  logic signed [ProdW-1:0]  den_r, snum_r, tnum_r;
  logic signed [DiffW-1:0]  dbx3_r, dby3_r;
  logic signed [CoordW-1:0] q0x3_r, q0y3_r;
  logic                     ign3_r;
  // stage 4: classification
  logic                     v4_r;
  seg_job_t                 job_r, job_nxt;

  logic pos_ok, neg_ok, t_pos, t_neg, s_pos, s_neg;
  logic signed [ProdW-1:0] tabs, dabs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= take;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    dax_r  <= DiffW'(p1x) - DiffW'(p0x);
    day_r  <= DiffW'(p1y) - DiffW'(p0y);
    dbx_r  <= DiffW'(q1x) - DiffW'(q0x);
    dby_r  <= DiffW'(q1y) - DiffW'(q0y);
    wx_r   <= DiffW'(q0x) - DiffW'(p0x);
    wy_r   <= DiffW'(q0y) - DiffW'(p0y);
    q0x1_r <= q0x;
    q0y1_r <= q0y;
    ign1_r <= ign;

    m0_r   <= dax_r * dby_r;
    m1_r   <= day_r * dbx_r;
    m2_r   <= wx_r * dby_r;
    m3_r   <= wy_r * dbx_r;
    m4_r   <= wx_r * day_r;
    m5_r   <= wy_r * dax_r;
    dbx2_r <= dbx_r;
    dby2_r <= dby_r;
    q0x2_r <= q0x1_r;
    q0y2_r <= q0y1_r;
    ign2_r <= ign1_r;

    den_r  <= m0_r - m1_r;
    snum_r <= m2_r - m3_r;
    tnum_r <= m4_r - m5_r;
    dbx3_r <= dbx2_r;
    dby3_r <= dby2_r;
    q0x3_r <= q0x2_r;
    q0y3_r <= q0y2_r;
    ign3_r <= ign2_r;

    job_r  <= job_nxt;
  end

  // Both parameters must lie between zero and den, in den's direction
  // (s only if A is bounded); this avoids negating before the compare.
  always_comb begin
    t_pos  = (tnum_r >= 0) && (tnum_r <= den_r);
    s_pos  = (snum_r >= 0) && (snum_r <= den_r);
    t_neg  = (tnum_r <= 0) && (tnum_r >= den_r);
    s_neg  = (snum_r <= 0) && (snum_r >= den_r);
    pos_ok = (den_r > 0) && t_pos && (ign3_r || s_pos);
    neg_ok = (den_r < 0) && t_neg && (ign3_r || s_neg);
    tabs   = den_r[ProdW-1] ? -tnum_r : tnum_r;
    dabs   = den_r[ProdW-1] ? -den_r : den_r;
    job_nxt.hit  = pos_ok || neg_ok;
    job_nxt.tnum = tabs[MagW-1:0];
    job_nxt.den  = dabs[MagW-1:0];
    job_nxt.dbx  = dbx3_r;
    job_nxt.dby  = dby3_r;
    job_nxt.q0x  = q0x3_r;
    job_nxt.q0y  = q0y3_r;
  end

  assign push = v4_r;
  assign job  = job_r;

endmodule

/* rtl/segi_queue.sv */
// Short queue of classified jobs between the front and back parts.
// Depends on segi_pkg.
module segi_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  segi_pkg::seg_job_t wr_job,
  output logic               rd_valid,
  output segi_pkg::seg_job_t rd_job,
  output logic               full
);
  import segi_pkg::*;

  seg_job_t               mem_r [QueueDepth];
  logic [QueueAw-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QueueAw:0]       count_r, count_nxt;
  logic                   pop, do_push;

  // The back part never stalls, so the head leaves whenever it is there.
  assign pop     = (count_r != '0);
  assign do_push = push && !full;
  assign full    = (count_r == (QueueAw+1)'(QueueDepth));

  always_comb begin
    count_nxt = count_r;
    if (do_push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  assign rd_valid = pop;
  assign rd_job   = mem_r[rd_ptr_r];

endmodule

/* rtl/segi_back.sv */
// Back part: split multiply of tnum by the B direction, a pipelined
// restoring divider by den, floor rounding and the final offset.
// Depends on segi_pkg.
module segi_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_vld,
  input  segi_pkg::seg_job_t                 job,
  output logic                               res_vld,
  output logic                               res_hit,
  output logic signed [segi_pkg::CoordW-1:0] res_x,
  output logic signed [segi_pkg::CoordW-1:0] res_y
);
  import segi_pkg::*;

  // multiply stage
  logic                     v1_r, hit1_r, negx1_r, negy1_r;
  logic [HiW+CoordW-1:0]    phx_r, phy_r;
  logic [LoW+CoordW-1:0]    plx_r, ply_r;
  logic [MagW-1:0]          den1_r;
  logic signed [CoordW-1:0] q0x1_r, q0y1_r;
  logic [DiffW-1:0]         absx, absy;

  // divider stages, index 0 is the summed numerator
  logic                     dv_r   [QuoW+1];
  logic                     dhit_r [QuoW+1];
  logic                     dnx_r  [QuoW+1];
  logic                     dny_r  [QuoW+1];
  logic [MagW-1:0]          dden_r [QuoW+1];
  logic [MagW-1:0]          rx_r   [QuoW+1];
  logic [MagW-1:0]          ry_r   [QuoW+1];
  logic [QuoW-1:0]          lx_r   [QuoW+1];
  logic [QuoW-1:0]          ly_r   [QuoW+1];
  logic [QuoW-1:0]          qx_r   [QuoW+1];
  logic [QuoW-1:0]          qy_r   [QuoW+1];
  logic signed [CoordW-1:0] dq0x_r [QuoW+1];
  logic signed [CoordW-1:0] dq0y_r [QuoW+1];

  logic [NumW-1:0]          nx, ny;

  logic                     ov_r, ohit_r;
  logic signed [CoordW-1:0] ox_r, oy_r;
  logic signed [SumW-1:0]   qsx, qsy, sx, sy;

  always_comb begin
    absx = job.dbx[DiffW-1] ? DiffW'(-job.dbx) : DiffW'(job.dbx);
    absy = job.dby[DiffW-1] ? DiffW'(-job.dby) : DiffW'(job.dby);
  end

  always_ff @(posedge clk) begin
    phx_r   <= job.tnum[MagW-1:LoW] * absx[CoordW-1:0];
    plx_r   <= job.tnum[LoW-1:0] * absx[CoordW-1:0];
    phy_r   <= job.tnum[MagW-1:LoW] * absy[CoordW-1:0];
    ply_r   <= job.tnum[LoW-1:0] * absy[CoordW-1:0];
    negx1_r <= job.dbx[DiffW-1];
    negy1_r <= job.dby[DiffW-1];
    den1_r  <= job.den;
    q0x1_r  <= job.q0x;
    q0y1_r  <= job.q0y;
    hit1_r  <= job.hit;
  end

  always_comb begin
    nx = (NumW'(phx_r) << LoW) + NumW'(plx_r);
    ny = (NumW'(phy_r) << LoW) + NumW'(ply_r);
  end

  // The quotient never exceeds |db|, so the numerator's upper part is
  // already below den and only the low bits need a stage each.
  always_ff @(posedge clk) begin
    rx_r[0]   <= nx[NumW-1:QuoW];
    ry_r[0]   <= ny[NumW-1:QuoW];
    lx_r[0]   <= nx[QuoW-1:0];
    ly_r[0]   <= ny[QuoW-1:0];
    qx_r[0]   <= '0;
    qy_r[0]   <= '0;
    dden_r[0] <= den1_r;
    dnx_r[0]  <= negx1_r;
    dny_r[0]  <= negy1_r;
    dq0x_r[0] <= q0x1_r;
    dq0y_r[0] <= q0y1_r;
    dhit_r[0] <= hit1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r     <= 1'b0;
      dv_r[0]  <= 1'b0;
    end else begin
      v1_r     <= in_vld;
      dv_r[0]  <= v1_r;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_div
    logic [MagW:0] tx, ty, ddx, ddy;
    logic          gex, gey;

    always_comb begin
      tx  = {rx_r[k], lx_r[k][QuoW-1]};
      ty  = {ry_r[k], ly_r[k][QuoW-1]};
      gex = (tx >= {1'b0, dden_r[k]});
      gey = (ty >= {1'b0, dden_r[k]});
      ddx = gex ? (tx - {1'b0, dden_r[k]}) : tx;
      ddy = gey ? (ty - {1'b0, dden_r[k]}) : ty;
    end

    always_ff @(posedge clk) begin
      rx_r[k+1]   <= ddx[MagW-1:0];
      ry_r[k+1]   <= ddy[MagW-1:0];
      lx_r[k+1]   <= lx_r[k] << 1;
      ly_r[k+1]   <= ly_r[k] << 1;
      qx_r[k+1]   <= {qx_r[k][QuoW-2:0], gex};
      qy_r[k+1]   <= {qy_r[k][QuoW-2:0], gey};
      dden_r[k+1] <= dden_r[k];
      dnx_r[k+1]  <= dnx_r[k];
      dny_r[k+1]  <= dny_r[k];
      dq0x_r[k+1] <= dq0x_r[k];
      dq0y_r[k+1] <= dq0y_r[k];
      dhit_r[k+1] <= dhit_r[k];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else begin
        dv_r[k+1] <= dv_r[k];
      end
    end
  end

  // A negative numerator rounds away from zero when the division is inexact,
  // which gives floor overall.
  always_comb begin
    qsx = dnx_r[QuoW]
        ? -(SumW'(qx_r[QuoW]) + SumW'(rx_r[QuoW] != '0))
        : SumW'(qx_r[QuoW]);
    qsy = dny_r[QuoW]
        ? -(SumW'(qy_r[QuoW]) + SumW'(ry_r[QuoW] != '0))
        : SumW'(qy_r[QuoW]);
    sx  = SumW'(dq0x_r[QuoW]) + qsx;
    sy  = SumW'(dq0y_r[QuoW]) + qsy;
  end

  always_ff @(posedge clk) begin
    ohit_r <= dhit_r[QuoW];
    ox_r   <= dhit_r[QuoW] ? sx[CoordW-1:0] : '0;
    oy_r   <= dhit_r[QuoW] ? sy[CoordW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= dv_r[QuoW];
    end
  end

  assign res_vld = ov_r;
  assign res_hit = ohit_r;
  assign res_x   = ox_r;
  assign res_y   = oy_r;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for segment_intersection: a queue-fed driver, a
// monitor and an exact integer predictor of the crossing point.
// Depends on segi_pkg and the segment_intersection RTL.
`timescale 1ns / 100ps

module tb_top;
  import segi_pkg::*;

  // One segment pair as it is presented on the input ports.
  typedef struct {
    logic signed [CoordW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    logic                     ign;
  } seg_pair_t;

  // One crossing result as it is expected on the output ports.
  typedef struct {
    logic                     hit;
    logic signed [CoordW-1:0] x, y;
  } crossing_t;

  localparam int unsigned Latency   = 40;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned NumRandom = 600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [CoordW-1:0] in_a_start_x = '0, in_a_start_y = '0;
  logic signed [CoordW-1:0] in_a_end_x = '0, in_a_end_y = '0;
  logic signed [CoordW-1:0] in_b_start_x = '0, in_b_start_y = '0;
  logic signed [CoordW-1:0] in_b_end_x = '0, in_b_end_y = '0;
  logic in_ignore_a_range = 1'b0;
  logic out_valid, out_hit;
  logic signed [CoordW-1:0] out_cross_x, out_cross_y;

  seg_pair_t pending_pairs[$];
  crossing_t expected_crossings[$];
  int unsigned sender_idle_pct = 20;
  int unsigned fail_count = 0;
  int unsigned pairs_sent = 0;
  int unsigned hits_seen = 0;
  int unsigned idle_cycles = 0;
  bit stimulus_done = 1'b0;

  always #1 clk = ~clk;

  segment_intersection i_dut (
    .clk, .rst_n, .start, .busy,
    .in_a_start_x, .in_a_start_y, .in_a_end_x, .in_a_end_y,
    .in_b_start_x, .in_b_start_y, .in_b_end_x, .in_b_end_y,
    .in_ignore_a_range,
    .out_valid, .out_hit, .out_cross_x, .out_cross_y
  );

  // Floor division of a signed numerator by a positive denominator.
  function automatic logic signed [199:0] floor_div(logic signed [199:0] n,
                                                    logic signed [199:0] d);
    logic signed [199:0] q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Clamp a wide value to the signed coordinate range.
  function automatic logic signed [CoordW-1:0] clamp_coord(logic signed [199:0] v);
    logic signed [199:0] lo, hi;
    lo = -(200'sd1 <<< (CoordW - 1));
    hi = (200'sd1 <<< (CoordW - 1)) - 1;
    if (v < lo) return lo[CoordW-1:0];
    if (v > hi) return hi[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

  // Exact crossing of A and B: s and t are kept as fractions over the
  // cross product of the two directions, and only the point is rounded.
  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [199:0] dax, day, dbx, dby, wx, wy, den, snum, tnum;
    crossing_t r;
    dax = 200'(p.ax1) - 200'(p.ax0);
    day = 200'(p.ay1) - 200'(p.ay0);
    dbx = 200'(p.bx1) - 200'(p.bx0);
    dby = 200'(p.by1) - 200'(p.by0);
    wx = 200'(p.bx0) - 200'(p.ax0);
    wy = 200'(p.by0) - 200'(p.ay0);
    den = dax * dby - day * dbx;
    snum = wx * dby - wy * dbx;
    tnum = wx * day - wy * dax;
    r = '{1'b0, '0, '0};
    // Parallel, antiparallel or zero-length segments never cross.
    if (den == 0) return r;
    if (den < 0) begin
      den = -den;
      snum = -snum;
      tnum = -tnum;
    end
    // End points themselves count as inside the ranges.
    if (tnum < 0 || tnum > den) return r;
    if (!p.ign && (snum < 0 || snum > den)) return r;
    r.hit = 1'b1;
    r.x = clamp_coord(200'(p.bx0) + floor_div(tnum * dbx, den));
    r.y = clamp_coord(200'(p.by0) + floor_div(tnum * dby, den));
    return r;
  endfunction

  function automatic seg_pair_t make_pair(int ax0, int ay0, int ax1, int ay1,
                                          int bx0, int by0, int bx1, int by1,
                                          bit ign);
    seg_pair_t p;
    p.ax0 = ax0; p.ay0 = ay0; p.ax1 = ax1; p.ay1 = ay1;
    p.bx0 = bx0; p.by0 = by0; p.bx1 = bx1; p.by1 = by1;
    p.ign = ign;
    return p;
  endfunction

  // A coordinate that is sometimes an extreme, sometimes small, sometimes a whole Q16.16 value, sometimes any.
  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 9)) inside
      0: return {1'b1, {(CoordW - 1){1'b0}}};
      1: return {1'b0, {(CoordW - 1){1'b1}}};
      [2:4]: return $urandom_range(0, 2000) - 1000;
      [5:6]: return ($urandom_range(0, 200) - 100) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // Random pair; most are built to cross near a shared point so that the
  // range checks and the rounding get exercised, not only the misses.
  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int cx, cy, scale;
    if ($urandom_range(0, 3) == 0) begin
      p = make_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0);
    end else begin
      scale = 1 << $urandom_range(0, 24);
      cx = $urandom_range(0, 2 * scale) - scale;
      cy = $urandom_range(0, 2 * scale) - scale;
      p.ax0 = cx - int'($urandom_range(0, scale)); p.ay0 = cy - int'($urandom_range(0, scale));
      p.ax1 = cx + int'($urandom_range(0, scale)); p.ay1 = cy + int'($urandom_range(0, scale));
      p.bx0 = cx + int'($urandom_range(0, scale)); p.by0 = cy - int'($urandom_range(0, scale));
      p.bx1 = cx - int'($urandom_range(0, scale)); p.by1 = cy + int'($urandom_range(0, scale));
      if ($urandom_range(0, 3) == 0) p.ax1 = p.ax0;
      if ($urandom_range(0, 3) == 0) begin
        p.ax1 = p.ax1 + ($urandom_range(0, 1) ? scale : -scale);
        p.ay1 = p.ay1 + ($urandom_range(0, 1) ? scale : -scale);
      end
    end
    p.ign = 1'($urandom_range(0, 1));
    return p;
  endfunction

  initial begin
    localparam int Mn = 32'sh8000_0000;
    localparam int Mx = 32'sh7fff_ffff;
    localparam int One = 32'sh0001_0000;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Directed pairs: a plain crossing, both verticals, parallel, collinear,
    // zero length, end points touching, s out of range with and without the
    // unbounded line, inexact rounding and the field extremes.
    pending_pairs.push_back(make_pair(0, 0, 2*One, 2*One, 0, 2*One, 2*One, 0, 0));
    pending_pairs.push_back(make_pair(One, 0, One, 2*One, 0, One, 2*One, One, 0));
    pending_pairs.push_back(make_pair(0, 0, 2*One, 0, One, -One, One, One, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, One, One, 0, One, One, 0));
    pending_pairs.push_back(make_pair(0, 0, One, One, 0, One, One, 2*One, 0));
    pending_pairs.push_back(make_pair(0, 0, 2*One, 2*One, One, One, 3*One, 3*One, 0));
    pending_pairs.push_back(make_pair(5, 5, 5, 5, 0, 0, 9, 9, 0));
    pending_pairs.push_back(make_pair(0, 0, 4, 0, 4, 0, 4, 4, 0));
    pending_pairs.push_back(make_pair(0, 0, 4, 0, 0, 0, 0, 4, 0));
    pending_pairs.push_back(make_pair(0, 0, 4, 0, 2, -4, 2, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 1, 0, 5, -1, 5, 1, 0));
    pending_pairs.push_back(make_pair(0, 0, 1, 0, 5, -1, 5, 1, 1));
    pending_pairs.push_back(make_pair(0, 0, 3, 1, 1, -1, -1, 2, 0));
    pending_pairs.push_back(make_pair(0, 0, 3, -1, 1, 1, -1, -2, 1));
    pending_pairs.push_back(make_pair(Mn, Mn, Mx, Mx, Mn, Mx, Mx, Mn, 0));
    pending_pairs.push_back(make_pair(Mx, Mn, Mn, Mx, Mn, Mn, Mx, Mx, 1));
    pending_pairs.push_back(make_pair(Mn, 0, Mx, 0, 0, Mn, 0, Mx, 0));
    pending_pairs.push_back(make_pair(Mn, Mn, Mn, Mx, Mx, Mn, Mx, Mx, 0));
    pending_pairs.push_back(make_pair(Mn, Mn, Mn + 1, Mn + 3, Mx, Mx, Mx - 7, Mx - 2, 1));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1, 1));
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        wait (pending_pairs.size() == 0);
        sender_idle_pct = 52;
      end
      if (i == 2 * NumRandom / 3) begin
        wait (pending_pairs.size() == 0);
        sender_idle_pct = 0;
      end
      pending_pairs.push_back(rand_pair());
    end
    stimulus_done = 1'b1;
  end

  // Driver: start stays high across back-to-back transfers and is only
  // lowered when the queue is empty or the sender chooses to idle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_crossings.push_back(predict_crossing(pending_pairs.pop_front()));
        pairs_sent <= pairs_sent + 1;
      end
      if (pending_pairs.size() != 0 && !(start && busy)
          && $urandom_range(0, 99) >= sender_idle_pct) begin
        start <= 1'b1;
        in_a_start_x <= pending_pairs[0].ax0;
        in_a_start_y <= pending_pairs[0].ay0;
        in_a_end_x <= pending_pairs[0].ax1;
        in_a_end_y <= pending_pairs[0].ay1;
        in_b_start_x <= pending_pairs[0].bx0;
        in_b_start_y <= pending_pairs[0].by0;
        in_b_end_x <= pending_pairs[0].bx1;
        in_b_end_y <= pending_pairs[0].by1;
        in_ignore_a_range <= pending_pairs[0].ign;
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    crossing_t exp_c;
    if (rst_n && out_valid) begin
      if (expected_crossings.size() == 0) begin
        $error("result with no pair outstanding");
        fail_count <= fail_count + 1;
      end else begin
        exp_c = expected_crossings.pop_front();
        if (out_hit && exp_c.hit) hits_seen <= hits_seen + 1;
        if (out_hit !== exp_c.hit) begin
          $error("hit: expected %0d, actual %0d", exp_c.hit, out_hit);
          fail_count <= fail_count + 1;
        end
        if (out_cross_x !== exp_c.x) begin
          $error("cross_x: expected %0d, actual %0d", exp_c.x, out_cross_x);
          fail_count <= fail_count + 1;
        end
        if (out_cross_y !== exp_c.y) begin
          $error("cross_y: expected %0d, actual %0d", exp_c.y, out_cross_y);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither an input nor a result transfers.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    wait (stimulus_done && pending_pairs.size() == 0 && !start);
    wait (expected_crossings.size() == 0);
    repeat (Latency + 10) @(posedge clk);
    $display("Sent %0d segment pairs under three idling patterns; %0d crossings hit.",
             pairs_sent, hits_seen);
    if (fail_count == 0 && expected_crossings.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
